// ===== rtl/psr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// psr_pkg: shared types and constants of the polyphase sinc resampler
// widths, request codes and the controller to datapath command bundle
// ----------------------------------------------------------------------------
package psr_pkg;

    localparam int HALF_WINDOW_DEF = 16;
    localparam int PHASE_COUNT_DEF = 512;
    localparam int SAMPLE_BITS_DEF = 24;

    localparam int COEF_BITS   = 18;
    localparam int INDEX_BITS  = 14;
    localparam int STEP_BITS   = 32;
    localparam int POS_BITS    = 60;
    localparam int FRAC_BITS   = 28;
    localparam int MAX_OUT     = 8;

    localparam logic [STEP_BITS-1:0] UNITY_STEP = 32'h1000_0000;
    localparam logic [STEP_BITS-1:0] MIN_STEP   = 32'h0200_0000;

    typedef enum logic [1:0] {
        REQ_COEF  = 2'd0,
        REQ_SAMPLE = 2'd1,
        REQ_FLUSH = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    // controller to datapath commands
    typedef struct packed {
        logic coef_wr;    // write coefficient from input item
        logic hist_fill;  // fill history with the new sample
        logic hist_push;  // shift history, new sample or repeat newest
        logic use_repeat; // pushed value is the newest sample
        logic idx_inc;    // advance input index
        logic mac_clr;    // clear accumulator, latch phase
        logic mac_en;     // one tap product into accumulator
        logic pos_adv;    // advance output position
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic due;        // an output is due at current position
    } t_stat;

endpackage
`default_nettype wire

// ===== rtl/psr_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// psr_datapath: coefficient memory, sample history and the tap mac
// one product per cycle, position and index counters
// ----------------------------------------------------------------------------
module psr_datapath #(
    parameter int HALF_WINDOW = psr_pkg::HALF_WINDOW_DEF,
    parameter int PHASE_COUNT = psr_pkg::PHASE_COUNT_DEF,
    parameter int SAMPLE_BITS = psr_pkg::SAMPLE_BITS_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire psr_pkg::t_cmd                  i_cmd,
    input  wire [$clog2(2*HALF_WINDOW)-1:0]     i_tap,
    input  wire [psr_pkg::STEP_BITS-1:0]        i_step,
    input  wire [psr_pkg::INDEX_BITS-1:0]       i_coef_index,
    input  wire signed [psr_pkg::COEF_BITS-1:0] i_coef_value,
    input  wire signed [SAMPLE_BITS-1:0]        i_sample,
    output psr_pkg::t_stat                      o_stat,
    output logic signed [SAMPLE_BITS-1:0]       o_result
);
    localparam int TAPS       = 2 * HALF_WINDOW;
    localparam int TAP_W      = $clog2(TAPS);
    localparam int PH_W       = $clog2(PHASE_COUNT);
    localparam int DEPTH      = PHASE_COUNT * TAPS;
    localparam int ADDR_W     = PH_W + TAP_W;
    localparam int PROD_W     = SAMPLE_BITS + psr_pkg::COEF_BITS;
    localparam int ACC_W      = PROD_W + TAP_W + 1;
    localparam int FB         = psr_pkg::FRAC_BITS;

    logic signed [psr_pkg::COEF_BITS-1:0] r_mem [DEPTH];
    logic signed [SAMPLE_BITS-1:0]        r_hist [TAPS];
    logic [31:0]                          r_idx;
    logic [psr_pkg::POS_BITS-1:0]         r_pos;
    logic [PH_W-1:0]                      r_phase;
    logic signed [psr_pkg::COEF_BITS-1:0] r_coef;
    logic signed [SAMPLE_BITS-1:0]        r_samp;
    logic                                 r_prod_v, r_mult_v;
    logic signed [PROD_W-1:0]             r_prod;
    logic signed [ACC_W-1:0]              r_acc;
    logic [psr_pkg::STEP_BITS-1:0]        w_step;
    logic [31:0]                          w_d;
    logic signed [ACC_W-1:0]              w_rnd;
    logic signed [ACC_W-17:0]             w_sh;

    // coefficient memory, registered read at current phase and tap
    always_ff @(posedge i_clk) begin
        if (i_cmd.coef_wr && ({2'b0, i_coef_index} < (psr_pkg::INDEX_BITS+2)'(DEPTH)))
            r_mem[i_coef_index[ADDR_W-1:0]] <= i_coef_value;
        r_coef <= r_mem[{r_phase, i_tap}];
        r_samp <= r_hist[i_tap];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < TAPS; t++) r_hist[t] <= '0;
        end else if (i_cmd.hist_fill) begin
            for (int t = 0; t < TAPS; t++) r_hist[t] <= i_sample;
        end else if (i_cmd.hist_push) begin
            for (int t = 0; t < TAPS - 1; t++) r_hist[t] <= r_hist[t+1];
            r_hist[TAPS-1] <= i_cmd.use_repeat ? r_hist[TAPS-1] : i_sample;
        end
    end

    assign w_step = (i_step < psr_pkg::MIN_STEP) ? psr_pkg::MIN_STEP : i_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_pos <= '0;
        end else begin
            if (i_cmd.idx_inc) r_idx <= r_idx + 32'd1;
            if (i_cmd.pos_adv) r_pos <= r_pos + {28'd0, w_step};
        end
    end

    // newest needed sample index is floor(pos) + half window, due if <= r_idx - 1
    assign w_d = r_idx - 32'd1 - 32'(HALF_WINDOW) - r_pos[psr_pkg::POS_BITS-1:FB];
    assign o_stat.due = ~w_d[31];

    // mac pipeline: read, multiply, accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_v <= 1'b0;
            r_mult_v <= 1'b0;
        end else begin
            r_prod_v <= i_cmd.mac_en;
            r_mult_v <= r_prod_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mac_clr) begin
            r_phase <= r_pos[FB-1:FB-PH_W];
            r_acc   <= '0;
        end else if (r_mult_v) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        r_prod <= PROD_W'(r_samp) * PROD_W'(r_coef);
    end

    assign w_rnd = r_acc + ACC_W'(32768);
    assign w_sh  = w_rnd[ACC_W-1:16];

    always_comb begin
        if (w_sh > (ACC_W-16)'(2**(SAMPLE_BITS-1) - 1))
            o_result = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        else if (w_sh < -(ACC_W-16)'(2**(SAMPLE_BITS-1)))
            o_result = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        else
            o_result = w_sh[SAMPLE_BITS-1:0];
    end
endmodule
`default_nettype wire

// ===== rtl/psr_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// psr_ctrl: sequencer of the resampler
// takes one item, drives the tap loop, hands results to the output register
// ----------------------------------------------------------------------------
module psr_ctrl #(
    parameter int HALF_WINDOW = psr_pkg::HALF_WINDOW_DEF,
    parameter int SAMPLE_BITS = psr_pkg::SAMPLE_BITS_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_valid,
    output logic                             o_ready,
    input  wire [1:0]                        i_type,
    input  wire [psr_pkg::STEP_BITS-1:0]     i_step,
    input  wire psr_pkg::t_stat              i_stat,
    input  wire signed [SAMPLE_BITS-1:0]     i_sample,
    input  wire signed [SAMPLE_BITS-1:0]     i_result,
    output psr_pkg::t_cmd                    o_cmd,
    output logic [$clog2(2*HALF_WINDOW)-1:0] o_tap,
    output logic                             o_valid,
    input  wire                              i_ready,
    output logic signed [SAMPLE_BITS-1:0]    o_data,
    output logic                             o_last
);
    localparam int TAPS  = 2 * HALF_WINDOW;
    localparam int TAP_W = $clog2(TAPS);
    localparam int FC_W  = $clog2(HALF_WINDOW + 1);
    localparam int CNT_W = $clog2(psr_pkg::MAX_OUT + 1);
    localparam int TAIL  = 3;

    typedef enum logic [2:0] {S_IDLE, S_CHECK, S_MAC, S_TAIL, S_EMIT, S_WAIT} t_state;

    t_state            r_state;
    logic [TAP_W-1:0]  r_tap;
    logic [1:0]        r_tail;
    logic [FC_W-1:0]   r_flush;
    logic              r_started;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_valid, r_last;
    logic signed [SAMPLE_BITS-1:0] r_data;
    logic              w_acc, w_unity, w_more;

    assign o_ready = (r_state == S_IDLE) && !r_valid;
    assign w_acc   = i_valid && o_ready;
    assign w_unity = (i_step == psr_pkg::UNITY_STEP);
    assign o_tap   = r_tap;
    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_last  = r_last;
    // another result follows the current one
    assign w_more  = (r_cnt < CNT_W'(psr_pkg::MAX_OUT)) && i_stat.due;

    always_comb begin
        o_cmd = '0;
        if (w_acc) begin
            case (i_type)
                psr_pkg::REQ_COEF: o_cmd.coef_wr = 1'b1;
                psr_pkg::REQ_SAMPLE: begin
                    if (r_flush == '0) begin
                        o_cmd.hist_fill = !r_started;
                        o_cmd.hist_push = r_started;
                        o_cmd.idx_inc   = 1'b1;
                    end
                end
                psr_pkg::REQ_FLUSH: begin
                    if (r_started && r_flush < FC_W'(HALF_WINDOW)) begin
                        o_cmd.hist_push  = 1'b1;
                        o_cmd.use_repeat = 1'b1;
                        o_cmd.idx_inc    = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        if (r_state == S_CHECK && i_stat.due) o_cmd.mac_clr = 1'b1;
        if (r_state == S_MAC) o_cmd.mac_en = 1'b1;
        if (r_state == S_EMIT && !r_valid) o_cmd.pos_adv = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_tap     <= '0;
            r_tail    <= '0;
            r_flush   <= '0;
            r_started <= 1'b0;
            r_cnt     <= '0;
            r_valid   <= 1'b0;
            r_last    <= 1'b0;
        end else begin
            if (r_valid && i_ready) r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_cnt <= '0;
                        if (o_cmd.idx_inc) begin
                            if (i_type == psr_pkg::REQ_SAMPLE) begin
                                r_started <= 1'b1;
                                if (w_unity) begin
                                    r_valid <= 1'b1;
                                    r_last  <= 1'b1;
                                    r_data  <= i_sample;
                                end else begin
                                    r_state <= S_CHECK;
                                end
                            end else begin
                                r_flush <= r_flush + 1'b1;
                                if (!w_unity) r_state <= S_CHECK;
                            end
                        end
                    end
                end
                S_CHECK: begin
                    r_state <= i_stat.due ? S_MAC : S_IDLE;
                    r_tap   <= '0;
                end
                S_MAC: begin
                    r_tap <= r_tap + 1'b1;
                    if (r_tap == TAP_W'(TAPS - 1)) begin
                        r_state <= S_TAIL;
                        r_tail  <= '0;
                    end
                end
                S_TAIL: begin
                    r_tail <= r_tail + 1'b1;
                    if (r_tail == 2'(TAIL - 1)) r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_valid) begin
                        r_data  <= i_result;
                        r_cnt   <= r_cnt + 1'b1;
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    // position advanced; decide if another output is due
                    if (!r_valid) begin
                        r_valid <= 1'b1;
                        r_last  <= !w_more;
                        r_tap   <= '0;
                        // next output goes through check to latch its phase
                        if (w_more) begin
                            r_state <= S_CHECK;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/polyphase_sinc_resampler.sv =====
`default_nettype none
// a result leaves after the check, tap loop, tail, emit and wait states; with unity step
//   the sample goes straight to the output register. Up to eight outputs per item, paced by the one
//   shared multiply-accumulate walking the taps; no new item is taken until the last result is out
// reset: synchronous active low, clears history, counters and handshake state;
//   the coefficient memory holds garbage until the host loads it
// ----------------------------------------------------------------------------
// polyphase_sinc_resampler: streaming polyphase windowed-sinc rate converter
// coefficient load, sample history, per-output tap mac with rounding and clip
// ----------------------------------------------------------------------------
module polyphase_sinc_resampler #(
    parameter int HALF_WINDOW = psr_pkg::HALF_WINDOW_DEF,
    parameter int PHASE_COUNT = psr_pkg::PHASE_COUNT_DEF,
    parameter int SAMPLE_BITS = psr_pkg::SAMPLE_BITS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire [31:0]  i_cfg_wdata,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // coef_index, coef_value, sample_in, zero pad
    input  wire [((psr_pkg::INDEX_BITS+psr_pkg::COEF_BITS+SAMPLE_BITS+7)/8)*8-1:0]
                        s_axis_tdata,
    input  wire [1:0]   s_axis_tuser, // req_type
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // sample_out, zero pad
    output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    localparam int CI = psr_pkg::INDEX_BITS;
    localparam int CV = psr_pkg::COEF_BITS;
    localparam int OW = ((SAMPLE_BITS + 7) / 8) * 8;

    logic [31:0]                r_step;
    psr_pkg::t_cmd              w_cmd;
    psr_pkg::t_stat             w_stat;
    logic [$clog2(2*HALF_WINDOW)-1:0] w_tap;
    logic signed [SAMPLE_BITS-1:0] w_result, w_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)      r_step <= psr_pkg::UNITY_STEP;
        else if (i_cfg_we) r_step <= i_cfg_wdata;
    end

    psr_ctrl #(.HALF_WINDOW(HALF_WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_ctrl (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_type(s_axis_tuser),
        .i_step(r_step), .i_stat(w_stat),
        .i_sample(s_axis_tdata[CI+CV+SAMPLE_BITS-1:CI+CV]),
        .i_result(w_result), .o_cmd(w_cmd), .o_tap(w_tap),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_data(w_out), .o_last(m_axis_tlast)
    );

    psr_datapath #(.HALF_WINDOW(HALF_WINDOW), .PHASE_COUNT(PHASE_COUNT),
                   .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .i_tap(w_tap), .i_step(r_step),
        .i_coef_index(s_axis_tdata[CI-1:0]),
        .i_coef_value(s_axis_tdata[CI+CV-1:CI]),
        .i_sample(s_axis_tdata[CI+CV+SAMPLE_BITS-1:CI+CV]),
        .o_stat(w_stat), .o_result(w_result)
    );

    assign m_axis_tdata = OW'($unsigned(w_out));
endmodule
`default_nettype wire

// ===== rtl/psr_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// psr_checker: port level checks of the resampler
// handshake holding and single item in flight
// ----------------------------------------------------------------------------
module psr_checker (
    input wire i_clk,
    input wire i_rst_n,
    input wire s_axis_tvalid,
    input wire s_axis_tready,
    input wire m_axis_tvalid,
    input wire m_axis_tready,
    input wire m_axis_tlast
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output dropped while stalled");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tlast))
        else $error("tlast changed while stalled");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while result pending");
    // more results of the same item follow, so no new item yet
    a_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> !s_axis_tready)
        else $error("input taken inside a run of results");
endmodule

bind polyphase_sinc_resampler psr_checker u_chk (
    .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tlast
);
`default_nettype wire
